/* hw/rtl/ezpt_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// ezpt_pkg
// Shared types, constants and helper functions of the Euler ZYX pose
// transform: fixed-point formats, the quarter-wave sine table and the
// matrix rebuild sequencer states.
// ---------------------------------------------------------------------------
package ezpt_pkg;

   localparam int SINE_DEPTH   = 1024;
   localparam int MATRIX_BITS  = 18;
   localparam int FRAC_BITS    = MATRIX_BITS - 2;
   localparam int COORD_W      = 32;
   localparam int ANGLE_W      = 16;
   localparam int QUARTER_TURN = 11520;
   localparam int FULL_TURN    = 46080;
   localparam int HALF_QUARTER = QUARTER_TURN / 2;
   localparam longint unsigned PI_Q30 = 64'd3373259426;

   localparam int SINE_W  = FRAC_BITS + 1;
   localparam int ADDR_W  = $clog2(SINE_DEPTH + 1);
   localparam int TURN_W  = $clog2(FULL_TURN);
   localparam int REM_W   = $clog2(QUARTER_TURN);
   localparam int NUM_W   = $clog2(QUARTER_TURN * SINE_DEPTH + QUARTER_TURN / 2 + 1);
   localparam int RECIP_SHIFT = NUM_W + 10;
   localparam longint unsigned RECIP =
      ((64'd1 << RECIP_SHIFT) + QUARTER_TURN - 1) / QUARTER_TURN;
   localparam int RECIP_W = $clog2(RECIP + 1);
   localparam int EST_W   = ADDR_W + 1;
   localparam int PROD_W  = MATRIX_BITS + 6;
   localparam int MUL_W   = MATRIX_BITS + COORD_W;
   localparam int ACC_W   = MUL_W + 2;
   localparam int SHIFT_W = ACC_W - FRAC_BITS;
   localparam int SUM_W   = SHIFT_W + 1;

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_POS_X = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_POS_Y = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_POS_Z = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ROLL  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_PITCH = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_YAW   = 3'd5;

   localparam logic [2:0] TRIG_LAST = 3'd5;

   typedef logic [SINE_W-1:0] sine_type;
   typedef sine_type sine_tab_type [0:SINE_DEPTH];
   typedef logic signed [MATRIX_BITS-1:0] entry_type;
   typedef logic signed [PROD_W-1:0] prod_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ANGLE,
      ST_EST,
      ST_INDEX,
      ST_ROM,
      ST_STORE,
      ST_PROD1,
      ST_PROD2,
      ST_ENTRY
   } rebuild_state_type;

   // Restoring long division, used only while the sine table is elaborated.
   function automatic longint unsigned udiv64(longint unsigned num,
                                              longint unsigned den);
      longint unsigned q;
      longint unsigned rem;
      q   = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem  = rem - den;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // Taylor series of sin in Q30, rounded to FRAC_BITS.
   function automatic sine_tab_type build_sine_tab();
      sine_tab_type t;
      longint unsigned theta;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned dvsr;
      for (int k = 0; k <= SINE_DEPTH; k++) begin
         theta = udiv64(PI_Q30 * longint'(k), 64'd2 * SINE_DEPTH);
         term  = theta;
         sum   = theta;
         for (int n = 1; n <= 10; n++) begin
            term = (term * theta) >> 30;
            term = (term * theta) >> 30;
            dvsr = longint'((2 * n) * (2 * n + 1));
            term = udiv64(term, dvsr);
            if ((n & 1) == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         t[k] = SINE_W'((sum + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
      end
      return t;
   endfunction

   function automatic prod_type fmul(prod_type a, prod_type b);
      logic signed [2*PROD_W-1:0] p;
      p = (2*PROD_W)'(a) * (2*PROD_W)'(b) + ((2*PROD_W)'(1) <<< (FRAC_BITS - 1));
      return PROD_W'(p >>> FRAC_BITS);
   endfunction

   function automatic entry_type sat_entry(prod_type v);
      prod_type hi;
      prod_type lo;
      hi = PROD_W'((1 <<< (MATRIX_BITS - 1)) - 1);
      lo = -PROD_W'(1 <<< (MATRIX_BITS - 1));
      if (v > hi) begin
         return entry_type'(hi);
      end else if (v < lo) begin
         return entry_type'(lo);
      end
      return entry_type'(v);
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/euler_zyx_pose_transform.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// euler_zyx_pose_transform
// Maps local points or directions into the world frame with a configured
// translation and a rotation R = Rz(yaw) Ry(pitch) Rx(roll), saturating.
// ---------------------------------------------------------------------------
//  Channel   Ports         Beat contents
//  request   req_*         func, local_x, local_y, local_z
//  response  rsp_*         world_x, world_y, world_z, saturated
//  control   csr_*         register index, write data
//
// Each beat passes three register stages (products, sums, translate and
// saturate); one beat can enter every cycle unless a full pipeline is
// stalled or the matrix is rebuilt. After reset or any angle write, a
// sequencer rebuilds the matrix: each sine or cosine lookup runs ANGLE,
// EST, INDEX, ROM and STORE through the registered sine ROM, then PROD1,
// PROD2 and ENTRY form it; req_ready is low throughout. A stalled response
// holds each stage that is full; empty stages still fill.
// ---------------------------------------------------------------------------
module euler_zyx_pose_transform (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  wire                                   req_func,
   input  wire  signed [ezpt_pkg::COORD_W-1:0]   req_local_x,
   input  wire  signed [ezpt_pkg::COORD_W-1:0]   req_local_y,
   input  wire  signed [ezpt_pkg::COORD_W-1:0]   req_local_z,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output logic signed [ezpt_pkg::COORD_W-1:0]   rsp_world_x,
   output logic signed [ezpt_pkg::COORD_W-1:0]   rsp_world_y,
   output logic signed [ezpt_pkg::COORD_W-1:0]   rsp_world_z,
   output logic                                  rsp_saturated,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [ezpt_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire  [ezpt_pkg::COORD_W-1:0]          csr_wdata
);

   localparam ezpt_pkg::sine_tab_type SINE_TAB = ezpt_pkg::build_sine_tab();

   logic signed [ezpt_pkg::COORD_W-1:0] pos_ff [0:2];
   logic signed [ezpt_pkg::ANGLE_W-1:0] roll_ff, pitch_ff, yaw_ff;
   ezpt_pkg::entry_type matrix_ff [0:8];
   ezpt_pkg::entry_type matrix_in [0:8];
   logic matrix_valid_ff;

   ezpt_pkg::rebuild_state_type state_ff, state_in;
   logic [2:0] k_ff;
   logic [1:0] quad_ff, quad_in;
   logic [ezpt_pkg::REM_W-1:0] r_ff, r_in;
   logic [ezpt_pkg::NUM_W-1:0] n_ff, n_in;
   logic [ezpt_pkg::EST_W-1:0] est_ff, est_in;
   logic [ezpt_pkg::ADDR_W-1:0] rom_addr_ff, rom_addr_in;
   logic neg_ff;
   ezpt_pkg::sine_type rom_data_ff;
   ezpt_pkg::entry_type trig_ff [0:5];
   ezpt_pkg::prod_type p1_ff [0:9];
   ezpt_pkg::prod_type p1_in [0:9];
   ezpt_pkg::prod_type p2_ff [0:3];
   ezpt_pkg::prod_type p2_in [0:3];

   logic angle_wr;
   logic signed [ezpt_pkg::ANGLE_W-1:0] ang_sel;
   logic signed [ezpt_pkg::ANGLE_W:0] ang_a;
   logic [ezpt_pkg::TURN_W-1:0] ang_u;
   logic [ezpt_pkg::NUM_W+ezpt_pkg::RECIP_W-1:0] est_prod;
   logic [ezpt_pkg::EST_W+ezpt_pkg::REM_W+1:0] est_back;
   logic [ezpt_pkg::EST_W-1:0] idx;

   assign csr_ready = 1'b1;
   assign angle_wr = csr_valid && (csr_index == ezpt_pkg::REG_ROLL
      || csr_index == ezpt_pkg::REG_PITCH || csr_index == ezpt_pkg::REG_YAW);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff[0] <= '0;
         pos_ff[1] <= '0;
         pos_ff[2] <= '0;
         roll_ff   <= '0;
         pitch_ff  <= '0;
         yaw_ff    <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            ezpt_pkg::REG_POS_X: pos_ff[0] <= csr_wdata;
            ezpt_pkg::REG_POS_Y: pos_ff[1] <= csr_wdata;
            ezpt_pkg::REG_POS_Z: pos_ff[2] <= csr_wdata;
            ezpt_pkg::REG_ROLL:  roll_ff   <= csr_wdata[ezpt_pkg::ANGLE_W-1:0];
            ezpt_pkg::REG_PITCH: pitch_ff  <= csr_wdata[ezpt_pkg::ANGLE_W-1:0];
            ezpt_pkg::REG_YAW:   yaw_ff    <= csr_wdata[ezpt_pkg::ANGLE_W-1:0];
            default: ;
         endcase
      end
   end

   // Matrix rebuild sequencer.
   always_comb begin
      state_in    = state_ff;
      quad_in     = quad_ff;
      r_in        = r_ff;
      n_in        = n_ff;
      est_in      = est_ff;
      rom_addr_in = rom_addr_ff;
      case (k_ff[2:1])
         2'd0:    ang_sel = roll_ff;
         2'd1:    ang_sel = pitch_ff;
         default: ang_sel = yaw_ff;
      endcase
      ang_a = (ezpt_pkg::ANGLE_W+1)'(ang_sel)
         + (k_ff[0] ? (ezpt_pkg::ANGLE_W+1)'(ezpt_pkg::QUARTER_TURN) : '0);
      if (ang_a < 0) begin
         ang_u = ezpt_pkg::TURN_W'(ang_a + (ezpt_pkg::ANGLE_W+1)'(ezpt_pkg::FULL_TURN));
      end else if (ang_a >= (ezpt_pkg::ANGLE_W+1)'(ezpt_pkg::FULL_TURN)) begin
         ang_u = ezpt_pkg::TURN_W'(ang_a - (ezpt_pkg::ANGLE_W+1)'(ezpt_pkg::FULL_TURN));
      end else begin
         ang_u = ezpt_pkg::TURN_W'(ang_a);
      end
      est_prod = (ezpt_pkg::NUM_W+ezpt_pkg::RECIP_W)'(n_ff)
         * (ezpt_pkg::NUM_W+ezpt_pkg::RECIP_W)'(ezpt_pkg::RECIP);
      est_back = (ezpt_pkg::EST_W+ezpt_pkg::REM_W+2)'(est_ff)
         * (ezpt_pkg::EST_W+ezpt_pkg::REM_W+2)'(ezpt_pkg::QUARTER_TURN);
      idx = (est_back > (ezpt_pkg::EST_W+ezpt_pkg::REM_W+2)'(n_ff)) ? est_ff - 1'b1 : est_ff;
      if (idx > ezpt_pkg::EST_W'(ezpt_pkg::SINE_DEPTH)) begin
         idx = ezpt_pkg::EST_W'(ezpt_pkg::SINE_DEPTH);
      end
      for (int i = 0; i < 10; i++) p1_in[i] = p1_ff[i];
      for (int i = 0; i < 4; i++) p2_in[i] = p2_ff[i];
      for (int i = 0; i < 9; i++) matrix_in[i] = matrix_ff[i];
      case (state_ff)
         ezpt_pkg::ST_IDLE: ;
         ezpt_pkg::ST_ANGLE: begin
            if (ang_u >= ezpt_pkg::TURN_W'(3 * ezpt_pkg::QUARTER_TURN)) begin
               quad_in = 2'd3;
               r_in = ezpt_pkg::REM_W'(ang_u - ezpt_pkg::TURN_W'(3 * ezpt_pkg::QUARTER_TURN));
            end else if (ang_u >= ezpt_pkg::TURN_W'(2 * ezpt_pkg::QUARTER_TURN)) begin
               quad_in = 2'd2;
               r_in = ezpt_pkg::REM_W'(ang_u - ezpt_pkg::TURN_W'(2 * ezpt_pkg::QUARTER_TURN));
            end else if (ang_u >= ezpt_pkg::TURN_W'(ezpt_pkg::QUARTER_TURN)) begin
               quad_in = 2'd1;
               r_in = ezpt_pkg::REM_W'(ang_u - ezpt_pkg::TURN_W'(ezpt_pkg::QUARTER_TURN));
            end else begin
               quad_in = 2'd0;
               r_in = ezpt_pkg::REM_W'(ang_u);
            end
            state_in = ezpt_pkg::ST_EST;
         end
         ezpt_pkg::ST_EST: begin
            n_in = ezpt_pkg::NUM_W'(r_ff) * ezpt_pkg::NUM_W'(ezpt_pkg::SINE_DEPTH)
               + ezpt_pkg::NUM_W'(ezpt_pkg::HALF_QUARTER);
            state_in = ezpt_pkg::ST_INDEX;
         end
         ezpt_pkg::ST_INDEX: begin
            est_in = ezpt_pkg::EST_W'(est_prod >> ezpt_pkg::RECIP_SHIFT);
            state_in = ezpt_pkg::ST_ROM;
         end
         ezpt_pkg::ST_ROM: begin
            rom_addr_in = quad_ff[0]
               ? ezpt_pkg::ADDR_W'(ezpt_pkg::EST_W'(ezpt_pkg::SINE_DEPTH) - idx)
               : ezpt_pkg::ADDR_W'(idx);
            state_in = ezpt_pkg::ST_STORE;
         end
         ezpt_pkg::ST_STORE: begin
            state_in = ezpt_pkg::ST_PROD1;
         end
         ezpt_pkg::ST_PROD1: begin
            // sr cr sp cp sy cy sit at trig 0..5.
            p1_in[0] = ezpt_pkg::fmul(ezpt_pkg::PROD_W'(trig_ff[0]), ezpt_pkg::PROD_W'(trig_ff[2]));
            p1_in[1] = ezpt_pkg::fmul(ezpt_pkg::PROD_W'(trig_ff[1]), ezpt_pkg::PROD_W'(trig_ff[2]));
            p1_in[2] = ezpt_pkg::fmul(ezpt_pkg::PROD_W'(trig_ff[3]), ezpt_pkg::PROD_W'(trig_ff[5]));
            p1_in[3] = ezpt_pkg::fmul(ezpt_pkg::PROD_W'(trig_ff[3]), ezpt_pkg::PROD_W'(trig_ff[4]));
            p1_in[4] = ezpt_pkg::fmul(ezpt_pkg::PROD_W'(trig_ff[1]), ezpt_pkg::PROD_W'(trig_ff[4]));
            p1_in[5] = ezpt_pkg::fmul(ezpt_pkg::PROD_W'(trig_ff[0]), ezpt_pkg::PROD_W'(trig_ff[4]));
            p1_in[6] = ezpt_pkg::fmul(ezpt_pkg::PROD_W'(trig_ff[1]), ezpt_pkg::PROD_W'(trig_ff[5]));
            p1_in[7] = ezpt_pkg::fmul(ezpt_pkg::PROD_W'(trig_ff[0]), ezpt_pkg::PROD_W'(trig_ff[5]));
            p1_in[8] = ezpt_pkg::fmul(ezpt_pkg::PROD_W'(trig_ff[0]), ezpt_pkg::PROD_W'(trig_ff[3]));
            p1_in[9] = ezpt_pkg::fmul(ezpt_pkg::PROD_W'(trig_ff[1]), ezpt_pkg::PROD_W'(trig_ff[3]));
            state_in = ezpt_pkg::ST_PROD2;
         end
         ezpt_pkg::ST_PROD2: begin
            p2_in[0] = ezpt_pkg::fmul(p1_ff[0], ezpt_pkg::PROD_W'(trig_ff[5]));
            p2_in[1] = ezpt_pkg::fmul(p1_ff[1], ezpt_pkg::PROD_W'(trig_ff[5]));
            p2_in[2] = ezpt_pkg::fmul(p1_ff[0], ezpt_pkg::PROD_W'(trig_ff[4]));
            p2_in[3] = ezpt_pkg::fmul(p1_ff[1], ezpt_pkg::PROD_W'(trig_ff[4]));
            state_in = ezpt_pkg::ST_ENTRY;
         end
         ezpt_pkg::ST_ENTRY: begin
            matrix_in[0] = ezpt_pkg::sat_entry(p1_ff[2]);
            matrix_in[1] = ezpt_pkg::sat_entry(p2_ff[0] - p1_ff[4]);
            matrix_in[2] = ezpt_pkg::sat_entry(p2_ff[1] + p1_ff[5]);
            matrix_in[3] = ezpt_pkg::sat_entry(p1_ff[3]);
            matrix_in[4] = ezpt_pkg::sat_entry(p2_ff[2] + p1_ff[6]);
            matrix_in[5] = ezpt_pkg::sat_entry(p2_ff[3] - p1_ff[7]);
            matrix_in[6] = ezpt_pkg::sat_entry(-ezpt_pkg::PROD_W'(trig_ff[2]));
            matrix_in[7] = ezpt_pkg::sat_entry(p1_ff[8]);
            matrix_in[8] = ezpt_pkg::sat_entry(p1_ff[9]);
            state_in = ezpt_pkg::ST_IDLE;
         end
         default: state_in = ezpt_pkg::ST_IDLE;
      endcase
      if (state_ff == ezpt_pkg::ST_STORE && k_ff != ezpt_pkg::TRIG_LAST) begin
         state_in = ezpt_pkg::ST_ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || angle_wr) begin
         state_ff        <= ezpt_pkg::ST_ANGLE;
         k_ff            <= '0;
         matrix_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ezpt_pkg::ST_STORE) begin
            k_ff <= (k_ff == ezpt_pkg::TRIG_LAST) ? '0 : k_ff + 1'b1;
         end
         if (state_ff == ezpt_pkg::ST_ENTRY) begin
            matrix_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quad_ff     <= quad_in;
      r_ff        <= r_in;
      n_ff        <= n_in;
      est_ff      <= est_in;
      rom_addr_ff <= rom_addr_in;
      neg_ff      <= quad_ff[1];
      rom_data_ff <= SINE_TAB[rom_addr_in];
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
      matrix_ff   <= matrix_in;
      if (state_ff == ezpt_pkg::ST_STORE) begin
         trig_ff[k_ff] <= neg_ff ? -ezpt_pkg::MATRIX_BITS'(rom_data_ff)
                                 : ezpt_pkg::MATRIX_BITS'(rom_data_ff);
      end
   end

   // Transform pipeline: products, sums, translate and saturate.
   logic v1_ff, v2_ff, v3_ff;
   logic en1, en2, en3;
   logic f1_ff, f2_ff;
   logic signed [ezpt_pkg::MUL_W-1:0] mul_ff [0:8];
   logic signed [ezpt_pkg::SHIFT_W-1:0] w_ff [0:2];
   logic signed [ezpt_pkg::COORD_W-1:0] loc [0:2];
   logic signed [ezpt_pkg::COORD_W-1:0] world_ff [0:2];
   logic sat_ff;
   logic signed [ezpt_pkg::ACC_W-1:0] acc [0:2];
   logic signed [ezpt_pkg::SUM_W-1:0] tot [0:2];
   logic signed [ezpt_pkg::COORD_W-1:0] world_in [0:2];
   logic sat_in;

   assign en3 = !v3_ff || rsp_ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_ready = en1 && matrix_valid_ff;
   assign loc[0] = req_local_x;
   assign loc[1] = req_local_y;
   assign loc[2] = req_local_z;

   always_comb begin
      sat_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         acc[i] = ezpt_pkg::ACC_W'(mul_ff[3*i]) + ezpt_pkg::ACC_W'(mul_ff[3*i+1])
            + ezpt_pkg::ACC_W'(mul_ff[3*i+2])
            + (ezpt_pkg::ACC_W'(1) <<< (ezpt_pkg::FRAC_BITS - 1));
         tot[i] = ezpt_pkg::SUM_W'(w_ff[i])
            + (f2_ff ? '0 : ezpt_pkg::SUM_W'(pos_ff[i]));
         if (tot[i] > signed'(ezpt_pkg::SUM_W'({1'b0, {(ezpt_pkg::COORD_W-1){1'b1}}}))) begin
            world_in[i] = {1'b0, {(ezpt_pkg::COORD_W-1){1'b1}}};
            sat_in = 1'b1;
         end else if (tot[i]
               < -signed'(ezpt_pkg::SUM_W'({1'b1, {(ezpt_pkg::COORD_W-1){1'b0}}}))) begin
            world_in[i] = {1'b1, {(ezpt_pkg::COORD_W-1){1'b0}}};
            sat_in = 1'b1;
         end else begin
            world_in[i] = ezpt_pkg::COORD_W'(tot[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid && req_ready;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         f1_ff <= req_func;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               mul_ff[3*i+j] <= ezpt_pkg::MUL_W'(matrix_ff[3*i+j]) * ezpt_pkg::MUL_W'(loc[j]);
            end
         end
      end
      if (en2) begin
         f2_ff <= f1_ff;
         for (int i = 0; i < 3; i++) begin
            w_ff[i] <= ezpt_pkg::SHIFT_W'(acc[i] >>> ezpt_pkg::FRAC_BITS);
         end
      end
      if (en3) begin
         world_ff <= world_in;
         sat_ff   <= sat_in;
      end
   end

   assign rsp_valid     = v3_ff;
   assign rsp_world_x   = world_ff[0];
   assign rsp_world_y   = world_ff[1];
   assign rsp_world_z   = world_ff[2];
   assign rsp_saturated = sat_ff;

   a_busy_not_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff != ezpt_pkg::ST_IDLE |-> !matrix_valid_ff)
      else $error("matrix marked valid during rebuild");
   a_k_range: assert property (@(posedge clock) disable iff (reset)
      k_ff <= ezpt_pkg::TRIG_LAST)
      else $error("trig index out of range");
   a_valid_from_entry: assert property (@(posedge clock) disable iff (reset)
      $rose(matrix_valid_ff) |-> $past(state_ff) == ezpt_pkg::ST_ENTRY)
      else $error("matrix valid set outside final rebuild step");
   a_no_accept_in_rebuild: assert property (@(posedge clock) disable iff (reset)
      state_ff != ezpt_pkg::ST_IDLE |-> !(req_valid && req_ready))
      else $error("beat accepted during matrix rebuild");

endmodule
`default_nettype wire
